@@ hw/rtl/llhist_pkg.sv @@
// Shared types, constants and bucket arithmetic for the log-linear latency histogram.
// No dependencies; every other file of the block imports this package.
package llhist_pkg;

	localparam int VALUE_BITS  = 24;
	localparam int COUNT_BITS  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int SUB_BITS    = 7;
	localparam int SUB_BUCKETS = 1 << SUB_BITS;
	localparam int EXP_BITS    = 5;
	localparam int NUM_BUCKETS = VALUE_BITS * SUB_BUCKETS;
	localparam int IDX_BITS    = EXP_BITS + SUB_BITS;
	localparam int PROD_BITS   = FRAC_BITS + 1 + COUNT_BITS;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [FRAC_BITS:0]    FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(NUM_BUCKETS - 1);

	localparam logic ACT_OBSERVE = 1'b0;
	localparam logic ACT_QUERY   = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [VALUE_BITS-1:0] sample;
		logic [FRAC_BITS:0]    quantile_fraction;
	} cmd_t;

	typedef struct packed {
		logic                  quantile_valid;
		logic [VALUE_BITS-1:0] quantile_value;
		logic [COUNT_BITS-1:0] total_count;
		logic [COUNT_BITS-1:0] underflow_total;
		logic [COUNT_BITS-1:0] overflow_total;
		logic [VALUE_BITS-1:0] max_seen;
	} result_t;

	typedef enum logic [1:0] {
		KIND_LOW,
		KIND_HIGH,
		KIND_BIN,
		KIND_QUERY
	} item_kind_t;

	typedef struct packed {
		item_kind_t            kind;
		logic [IDX_BITS-1:0]   idx;
		logic [VALUE_BITS-1:0] sample;
		logic [FRAC_BITS:0]    frac;
	} entry_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_BIN_WR,
		B_RANK,
		B_RANK2,
		B_SCAN
	} back_state_t;

	// Bucket index of a nonzero sample: octave in the upper bits, linear sub-bucket below.
	function automatic logic [IDX_BITS-1:0] slot_of(input logic [VALUE_BITS-1:0] v);
		logic [EXP_BITS-1:0]            e;
		logic [VALUE_BITS-1:0]          rem;
		logic [VALUE_BITS+SUB_BITS-1:0] t;
		e = '0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (v[i]) e = EXP_BITS'(i);
		end
		rem = v - (VALUE_BITS'(1) << e);
		t = ({{SUB_BITS{1'b0}}, rem} << SUB_BITS) >> e;
		return {e, t[SUB_BITS-1:0]};
	endfunction

	// Largest value that falls into a bucket.
	function automatic logic [VALUE_BITS-1:0] slot_top(input logic [IDX_BITS-1:0] idx);
		logic [EXP_BITS-1:0]              e;
		logic [VALUE_BITS+SUB_BITS:0]     num;
		logic [VALUE_BITS+SUB_BITS:0]     span;
		logic [VALUE_BITS:0]              top;
		e = idx[IDX_BITS-1:SUB_BITS];
		num = (VALUE_BITS+SUB_BITS+1)'({1'b0, idx[SUB_BITS-1:0]} + 8'd1) << e;
		span = (num + (VALUE_BITS+SUB_BITS+1)'(SUB_BUCKETS - 1)) >> SUB_BITS;
		top = ((VALUE_BITS+1)'(1) << e) + span[VALUE_BITS:0] - (VALUE_BITS+1)'(1);
		return top[VALUE_BITS-1:0];
	endfunction

endpackage

@@ hw/rtl/llhist_front.sv @@
// Front end: accepts commands, classifies samples into buckets and queues the work.
// Depends on llhist_pkg.
module llhist_front import llhist_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cmd_t                  cmd,
	input  logic [VALUE_BITS-1:0] max_latency,
	input  logic                  hold,
	output logic                  busy,
	output logic                  q_valid,
	output entry_t                q_entry,
	input  logic                  q_pop
);

	entry_t      fifo_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	entry_t      new_entry;
	logic        push;

	assign busy    = hold || (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_entry = fifo_q[rptr_q];

	always_comb begin
		new_entry.idx    = slot_of(cmd.sample);
		new_entry.sample = cmd.sample;
		new_entry.frac   = cmd.quantile_fraction;
		if (cmd.action == ACT_QUERY) begin
			new_entry.kind = KIND_QUERY;
		end else if (cmd.sample == '0) begin
			new_entry.kind = KIND_LOW;
		end else if (cmd.sample > max_latency) begin
			new_entry.kind = KIND_HIGH;
		end else begin
			new_entry.kind = KIND_BIN;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (q_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ hw/rtl/llhist_back.sv @@
// Back end: bucket memory, counters, read-modify-write of buckets and the quantile scan.
// Depends on llhist_pkg.
module llhist_back import llhist_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  entry_t  q_entry,
	output logic    q_pop,
	output logic    clearing,
	output logic    done,
	output result_t result
);

	logic [COUNT_BITS-1:0] mem [NUM_BUCKETS];
	logic [COUNT_BITS-1:0] rdata_q;

	back_state_t           state_q, state_d;
	logic [IDX_BITS-1:0]   addr_q;
	logic [IDX_BITS-1:0]   idx_s1;
	logic                  pend_s1;
	logic [VALUE_BITS-1:0] bsample_q;
	logic [FRAC_BITS:0]    frac_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [COUNT_BITS:0]   rank_q;
	logic [COUNT_BITS-1:0] cum_q;
	logic [COUNT_BITS-1:0] total_q, low_q, high_q;
	logic [VALUE_BITS-1:0] largest_q;
	logic                  done_q;
	result_t               result_q;

	logic [IDX_BITS-1:0]   raddr;
	logic                  we;
	logic [IDX_BITS-1:0]   waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [COUNT_BITS:0]   cum_sum;
	logic [COUNT_BITS-1:0] cum_sat;
	logic [VALUE_BITS-1:0] top_val;

	assign clearing = (state_q == B_CLEAR);
	assign done     = done_q;
	assign result   = result_q;

	always_comb begin
		cum_sum = {1'b0, cum_q} + {1'b0, rdata_q};
		cum_sat = cum_sum[COUNT_BITS] ? COUNT_MAX : cum_sum[COUNT_BITS-1:0];
		top_val = slot_top(idx_s1);
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		raddr   = addr_q;
		we      = 1'b0;
		waddr   = addr_q;
		wdata   = '0;
		case (state_q)
			B_CLEAR: begin
				we = 1'b1;
				if (addr_q == LAST_IDX) state_d = B_IDLE;
			end
			B_IDLE: begin
				raddr = q_entry.idx;
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_entry.kind)
						KIND_BIN:   state_d = B_BIN_WR;
						KIND_QUERY: state_d = B_RANK;
						default:    state_d = B_IDLE;
					endcase
				end
			end
			B_BIN_WR: begin
				we      = 1'b1;
				wdata   = (rdata_q == COUNT_MAX) ? COUNT_MAX : rdata_q + 1'b1;
				state_d = B_IDLE;
			end
			B_RANK: begin
				if (total_q == '0 || frac_q == '0 || frac_q > FRAC_ONE) state_d = B_IDLE;
				else state_d = B_RANK2;
			end
			B_RANK2: state_d = B_SCAN;
			B_SCAN: begin
				if (pend_s1 && ({1'b0, cum_sat} >= rank_q || idx_s1 == LAST_IDX))
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Payload registers of the current item, the rank product and the registered result.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			bsample_q <= q_entry.sample;
			frac_q    <= q_entry.frac;
		end
		prod_q <= PROD_BITS'(frac_q) * PROD_BITS'(total_q);
		if (state_q == B_RANK2)
			rank_q <= (COUNT_BITS+1)'((prod_q + PROD_BITS'({FRAC_BITS{1'b1}})) >> FRAC_BITS);
		result_q.total_count     <= total_q;
		result_q.underflow_total <= low_q;
		result_q.overflow_total  <= high_q;
		result_q.max_seen        <= largest_q;
		if (state_q == B_SCAN && pend_s1 && {1'b0, cum_sat} >= rank_q) begin
			result_q.quantile_valid <= 1'b1;
			result_q.quantile_value <= (top_val < largest_q) ? top_val : largest_q;
		end else begin
			result_q.quantile_valid <= 1'b0;
			result_q.quantile_value <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			addr_q    <= '0;
			idx_s1    <= '0;
			pend_s1   <= 1'b0;
			cum_q     <= '0;
			total_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			largest_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				B_CLEAR: addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
				B_IDLE: begin
					if (q_valid) begin
						addr_q <= q_entry.idx;
						if (q_entry.kind == KIND_LOW && low_q != COUNT_MAX)
							low_q <= low_q + 1'b1;
						if (q_entry.kind == KIND_HIGH && high_q != COUNT_MAX)
							high_q <= high_q + 1'b1;
					end
				end
				B_BIN_WR: begin
					if (total_q != COUNT_MAX) total_q <= total_q + 1'b1;
					if (bsample_q > largest_q) largest_q <= bsample_q;
				end
				B_RANK: begin
					// An empty histogram or an out-of-range fraction answers at once.
					if (total_q == '0 || frac_q == '0 || frac_q > FRAC_ONE) done_q <= 1'b1;
				end
				B_RANK2: begin
					addr_q  <= '0;
					pend_s1 <= 1'b0;
					cum_q   <= '0;
				end
				B_SCAN: begin
					// Read data of the bucket addressed last cycle is summed this cycle.
					if (addr_q != LAST_IDX) addr_q <= addr_q + 1'b1;
					idx_s1  <= addr_q;
					pend_s1 <= 1'b1;
					if (pend_s1) begin
						cum_q <= cum_sat;
						if ({1'b0, cum_sat} >= rank_q || idx_s1 == LAST_IDX) begin
							done_q  <= 1'b1;
							pend_s1 <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/log_linear_latency_histogram_core.sv @@
// Top level of the log-linear latency histogram: APB register, front end and back end.
// Depends on llhist_pkg, llhist_front and llhist_back.
//
// Usage: a command (observe a sample or query a quantile) is taken on a clock edge
// with start high and busy low. Observes give no result. A query gives exactly one
// result beat on result, marked by a one-cycle done strobe; the receiver cannot stall.
// Commands pass a two-entry registered queue; the back end handles one at a time
// from it. An underflow or overflow sample is counted as it leaves the queue, an
// in-range sample by a bucket read, then a write. A query checks the count and its
// fraction in B_RANK and answers there if the histogram is empty or the fraction is
// out of range; else it takes the rank in B_RANK2 and scans the buckets in B_SCAN up
// to the bucket that holds the rank or the last bucket. The done strobe is registered
// and comes in the cycle after the query's last back-end state.
// The APB register max_latency sits at address 0; pready is always high.
// After reset the bucket memory is cleared one entry a cycle, all 3072 entries, during
// which busy stays high. Configuration writes are accepted at any time.
module log_linear_latency_histogram_core import llhist_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [VALUE_BITS-1:0] max_latency_q;
	logic                  clearing;
	logic                  q_valid;
	logic                  q_pop;
	entry_t                q_entry;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-VALUE_BITS){1'b0}}, max_latency_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_latency_q <= VALUE_MAX;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			max_latency_q <= pwdata[VALUE_BITS-1:0];
		end
	end

	llhist_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.max_latency (max_latency_q),
		.hold        (clearing),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	llhist_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

@@ verif/log_linear_latency_histogram_core_tb.sv @@
// Self-checking testbench for log_linear_latency_histogram_core: observe and quantile
// commands with random gaps, max_latency written over APB between phases.
// Depends on llhist_pkg and the RTL of the histogram core only.
module log_linear_latency_histogram_core_tb;
	import llhist_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 24_000_000;
	localparam int SETTLE_TICKS = 40;

	typedef enum logic [1:0] {
		STEP_CMD,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		cmd_t        cmd;
		int          gap;
		logic [2:0]  addr;
		logic [31:0] data;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        done;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	log_linear_latency_histogram_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// Model of the histogram state.
	logic [COUNT_BITS-1:0] bin_count [NUM_BUCKETS];
	logic [COUNT_BITS-1:0] in_range_total, zero_total, over_total;
	logic [VALUE_BITS-1:0] peak_sample;
	logic [VALUE_BITS-1:0] latency_limit;

	step_t   pending_steps[$];
	result_t expected_reports[$];
	int      fail_count = 0;
	int      cycle_count = 0;

	function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
			longint unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return (s > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(s);
	endfunction

	function automatic int bin_of(logic [VALUE_BITS-1:0] v);
		int e;
		longint unsigned base, sub;
		e = 0;
		for (int i = 0; i < VALUE_BITS; i++)
			if (v[i]) e = i;
		base = 64'd1 << e;
		sub = ((longint'(v) - base) * SUB_BUCKETS) / base;
		if (sub > SUB_BUCKETS - 1) sub = SUB_BUCKETS - 1;
		return e * SUB_BUCKETS + int'(sub);
	endfunction

	function automatic logic [VALUE_BITS-1:0] bin_upper(int idx);
		longint unsigned base, num, span;
		base = 64'd1 << (idx / SUB_BUCKETS);
		num = longint'(idx % SUB_BUCKETS + 1) * base;
		span = (num + SUB_BUCKETS - 1) / SUB_BUCKETS;
		return VALUE_BITS'(base + span - 1);
	endfunction

	task automatic apply_command(cmd_t c);
		result_t         r;
		longint unsigned rank, cum;
		logic [VALUE_BITS-1:0] up;
		if (c.action == ACT_OBSERVE) begin
			if (c.sample == 0) begin
				zero_total = sat_add(zero_total, 64'd1);
			end else if (c.sample > latency_limit) begin
				over_total = sat_add(over_total, 64'd1);
			end else begin
				bin_count[bin_of(c.sample)] = sat_add(bin_count[bin_of(c.sample)], 64'd1);
				in_range_total = sat_add(in_range_total, 64'd1);
				if (c.sample > peak_sample) peak_sample = c.sample;
			end
			return;
		end
		r = '0;
		if (in_range_total != 0 && c.quantile_fraction != 0
				&& c.quantile_fraction <= FRAC_ONE) begin
			// Exact ceil(fraction * count / 2^16); the product fits in 64 bits.
			rank = (longint'(c.quantile_fraction) * longint'(in_range_total)
				+ 64'hFFFF) >> FRAC_BITS;
			cum = 0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				cum = sat_add(COUNT_BITS'(cum), 64'(bin_count[i]));
				if (cum >= rank) begin
					up = bin_upper(i);
					r.quantile_value = (up < peak_sample) ? up : peak_sample;
					r.quantile_valid = 1'b1;
					break;
				end
			end
		end
		r.total_count = in_range_total;
		r.underflow_total = zero_total;
		r.overflow_total = over_total;
		r.max_seen = peak_sample;
		expected_reports.push_back(r);
	endtask

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Driver: command beats from the pending queue, APB writes once the block is idle.
	int   gap_left = 0;
	int   settle = 0;
	int   apb_phase = 0;
	logic start_nx, psel_nx, pen_nx;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) apply_command(cmd);
			start_nx = start && busy;
			psel_nx = 1'b0;
			pen_nx = 1'b0;
			if (apb_phase == 1) begin
				psel_nx = 1'b1;
				pen_nx = 1'b1;
				apb_phase = 2;
			end else if (apb_phase == 2) begin
				// The write took effect at this edge.
				if (paddr == 3'd0) latency_limit = pwdata[VALUE_BITS-1:0];
				apb_phase = 0;
				void'(pending_steps.pop_front());
			end else if (!start_nx && pending_steps.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_steps[0].kind == STEP_CMD) begin
					cmd <= pending_steps[0].cmd;
					start_nx = 1'b1;
					gap_left = pending_steps[0].gap;
					void'(pending_steps.pop_front());
				end else if (expected_reports.size() == 0 && !busy && !start) begin
					if (settle < SETTLE_TICKS) begin
						settle++;
					end else begin
						settle = 0;
						if (pending_steps[0].kind == STEP_CFG) begin
							psel_nx = 1'b1;
							pwrite <= 1'b1;
							paddr <= pending_steps[0].addr;
							pwdata <= pending_steps[0].data;
							apb_phase = 1;
						end else begin
							void'(pending_steps.pop_front());
						end
					end
				end else begin
					settle = 0;
				end
			end
			start <= start_nx;
			psel <= psel_nx;
			penable <= pen_nx;
		end
	end

	// Monitor: every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$error("result beat with no query outstanding");
				fail_count++;
			end else begin
				e = expected_reports.pop_front();
				if (result.quantile_valid !== e.quantile_valid) begin
					$error("quantile_valid: expected %0d, got %0d",
						e.quantile_valid, result.quantile_valid);
					fail_count++;
				end
				if (result.quantile_value !== e.quantile_value) begin
					$error("quantile_value: expected %0d, got %0d",
						e.quantile_value, result.quantile_value);
					fail_count++;
				end
				if (result.total_count !== e.total_count) begin
					$error("total_count: expected %0d, got %0d",
						e.total_count, result.total_count);
					fail_count++;
				end
				if (result.underflow_total !== e.underflow_total) begin
					$error("underflow_total: expected %0d, got %0d",
						e.underflow_total, result.underflow_total);
					fail_count++;
				end
				if (result.overflow_total !== e.overflow_total) begin
					$error("overflow_total: expected %0d, got %0d",
						e.overflow_total, result.overflow_total);
					fail_count++;
				end
				if (result.max_seen !== e.max_seen) begin
					$error("max_seen: expected %0d, got %0d", e.max_seen, result.max_seen);
					fail_count++;
				end
			end
		end
	end

	// Stimulus construction.
	logic [VALUE_BITS-1:0] plan_limit;

	function automatic int pick_gap(bit no_gaps);
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_sample();
		int r, e;
		r = $urandom_range(0, 19);
		e = $urandom_range(0, VALUE_BITS - 1);
		case (r)
			0: return '0;
			1: return VALUE_MAX;
			2: return plan_limit;
			3: return (plan_limit == VALUE_MAX) ? VALUE_MAX : plan_limit + 1'b1;
			4, 5, 6: return VALUE_BITS'($urandom_range(1, 300));
			default: return VALUE_BITS'((32'd1 << e) | ($urandom & ((32'd1 << e) - 1)));
		endcase
	endfunction

	function automatic logic [FRAC_BITS:0] pick_fraction();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FRAC_ONE;
			2: return (FRAC_BITS+1)'($urandom_range(65537, 131071));
			3: return (FRAC_BITS+1)'(1);
			default: return (FRAC_BITS+1)'($urandom_range(1, 65536));
		endcase
	endfunction

	task automatic add_command(logic act, logic [VALUE_BITS-1:0] s, logic [FRAC_BITS:0] f,
			int gap);
		step_t st;
		st.kind = STEP_CMD;
		st.cmd.action = act;
		st.cmd.sample = s;
		st.cmd.quantile_fraction = f;
		st.gap = gap;
		st.addr = '0;
		st.data = '0;
		pending_steps.push_back(st);
	endtask

	task automatic add_write(logic [2:0] a, logic [31:0] d);
		step_t st;
		st = '{kind: STEP_CFG, cmd: '0, gap: 0, addr: a, data: d};
		pending_steps.push_back(st);
		if (a == 3'd0) plan_limit = d[VALUE_BITS-1:0];
	endtask

	task automatic add_phase(logic [VALUE_BITS-1:0] limit, int n, bit no_gaps);
		step_t st;
		add_write(3'd0, 32'(limit));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 8)
				add_command(ACT_QUERY, VALUE_BITS'($urandom), pick_fraction(),
					pick_gap(no_gaps));
			else
				add_command(ACT_OBSERVE, pick_sample(), (FRAC_BITS+1)'($urandom),
					pick_gap(no_gaps));
		end
		// Hold off until every pending quantile has been answered.
		st = '{kind: STEP_DRAIN, cmd: '0, gap: 0, addr: '0, data: '0};
		pending_steps.push_back(st);
		add_command(ACT_QUERY, '0, FRAC_ONE, 0);
	endtask

	initial begin
		for (int i = 0; i < NUM_BUCKETS; i++) bin_count[i] = '0;
		in_range_total = '0;
		zero_total = '0;
		over_total = '0;
		peak_sample = '0;
		latency_limit = VALUE_MAX;
		plan_limit = VALUE_MAX;

		// Directed: empty histogram, bad fractions, field extremes, bucket edges.
		add_command(ACT_QUERY, '0, FRAC_ONE, 0);
		add_command(ACT_OBSERVE, '0, '0, 0);
		add_command(ACT_QUERY, '0, (FRAC_BITS+1)'(1), 0);
		add_command(ACT_OBSERVE, 24'd1, '0, 0);
		add_command(ACT_OBSERVE, VALUE_MAX, '1, 0);
		add_command(ACT_OBSERVE, 24'd255, '0, 1);
		add_command(ACT_OBSERVE, 24'd256, '0, 0);
		add_command(ACT_OBSERVE, 24'd257, '0, 0);
		add_command(ACT_OBSERVE, 24'h800000, '0, 2);
		add_command(ACT_QUERY, '0, '0, 0);
		add_command(ACT_QUERY, '0, (FRAC_BITS+1)'(1), 0);
		add_command(ACT_QUERY, '0, 17'd32768, 0);
		add_command(ACT_QUERY, '0, FRAC_ONE, 0);
		add_command(ACT_QUERY, '0, 17'd65537, 0);
		add_command(ACT_QUERY, VALUE_MAX, '1, 0);
		add_write(3'd4, 32'd5);
		add_write(3'd0, 32'd1);
		add_command(ACT_OBSERVE, 24'd1, '0, 0);
		add_command(ACT_OBSERVE, 24'd2, '0, 0);
		add_command(ACT_OBSERVE, '0, '0, 0);
		add_command(ACT_QUERY, '0, FRAC_ONE, 0);

		add_phase(VALUE_MAX, 420, 1'b0);
		add_phase(24'd1, 200, 1'b1);
		add_phase(24'd1000, 300, 1'b0);
		add_phase(VALUE_BITS'($urandom_range(2, 24'hFFFFFE)), 300, 1'b0);
		add_phase(24'h10000, 250, 1'b1);
		add_phase(VALUE_MAX, 360, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_steps.size() == 0 && !start);
		wait (expected_reports.size() == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/llhist_pkg.sv
hw/rtl/llhist_front.sv
hw/rtl/llhist_back.sv
hw/rtl/log_linear_latency_histogram_core.sv
verif/log_linear_latency_histogram_core_tb.sv
